// ===== design/cyrc_pkg.sv =====
// ----------------------------------------------------------------------------
// cyrc_pkg
// Shared types and constants of the cyclic rotation canonicalizer.
// ----------------------------------------------------------------------------
package cyrc_pkg;

	localparam int WORD_BITS      = 32;
	localparam int MAX_SITES_DEF  = 32;
	localparam int LEN_W          = 6;
	localparam int MOM_W          = 5;
	localparam int SHIFT_W        = 5;
	localparam int SPIN_W         = 7;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 8;
	localparam int PROD_W         = LEN_W + MOM_W;

	localparam logic [LEN_W-1:0] CHAIN_LENGTH_RST = LEN_W'(32);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHAIN_LENGTH = 8'd0,
		REG_MOMENTUM     = 8'd1,
		REG_SPIN_FILTER  = 8'd2,
		REG_TARGET_SPIN  = 8'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_MUL,
		ST_MOD,
		ST_DONE
	} fsm_state_t;

	typedef struct packed {
		logic               load;
		logic               rotate;
		logic [SHIFT_W-1:0] last_idx;
	} cell_ctrl_t;

endpackage

// ===== design/cyrc_cell.sv =====
// ----------------------------------------------------------------------------
// cyrc_cell
// One site of the ring: loads its masked bit and rotates toward site zero.
// ----------------------------------------------------------------------------
module cyrc_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  cyrc_pkg::cell_ctrl_t ctrl,
	input  logic                load_bit,
	input  logic                right_bit,
	input  logic                wrap_bit,
	output logic                site_q,
	output logic                site_next
);
	import cyrc_pkg::*;

	localparam logic [SHIFT_W-1:0] IDX_V = SHIFT_W'(IDX);

	logic in_ring;

	assign in_ring   = (IDX_V <= ctrl.last_idx);
	// last live site takes the bit leaving site zero
	assign site_next = (IDX_V == ctrl.last_idx) ? wrap_bit : (right_bit & in_ring);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			site_q <= load_bit & in_ring;
		end else if (ctrl.rotate) begin
			site_q <= site_next;
		end
	end

endmodule

// ===== design/cyrc_pmod.sv =====
// ----------------------------------------------------------------------------
// cyrc_pmod
// Period times momentum, then remainder by the chain length, one bit a cycle.
// ----------------------------------------------------------------------------
module cyrc_pmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cyrc_pkg::LEN_W-1:0]  period,
	input  logic [cyrc_pkg::MOM_W-1:0]  mom,
	input  logic [cyrc_pkg::LEN_W-1:0]  divisor,
	output logic                        done,
	output logic                        rem_zero
);
	import cyrc_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] dvd_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W:0]    trial;
	logic [LEN_W:0]    div_ext;

	assign trial   = {rem_q, dvd_q[PROD_W-1]};
	assign div_ext = {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= PROD_W'(period) * PROD_W'(mom);
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			if (trial >= div_ext) begin
				rem_q <= LEN_W'(trial - div_ext);
			end else begin
				rem_q <= LEN_W'(trial);
			end
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule

// ===== design/cyclic_rotation_canonicalizer.sv =====
// ----------------------------------------------------------------------------
// cyclic_rotation_canonicalizer
// Smallest cyclic rotation, orbit period and spin of a ring state word.
// ----------------------------------------------------------------------------
// One state word is worked on at a time. The word is loaded into a row of
// one-bit site cells that rotates it by one site per cycle for the rotation
// search over an effective chain length L. The momentum test then starts the
// remainder unit, runs its eleven shift-and-subtract remainder steps and
// registers its flag; the output register is loaded after that, and later
// while an earlier result still waits to be read. The next word is taken in
// the cycle after that load, even while that result still waits to be read.
// Configuration writes are always ready and take effect at once; they must
// not be made while a word is in flight.
// ----------------------------------------------------------------------------
module cyclic_rotation_canonicalizer #(
	parameter int MAX_SITES = cyrc_pkg::MAX_SITES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cyrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cyrc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             state_valid,
	output logic                             state_stall,
	input  logic [cyrc_pkg::WORD_BITS-1:0]   state_word,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [cyrc_pkg::WORD_BITS-1:0]   canonical_word,
	output logic [cyrc_pkg::SHIFT_W-1:0]     shift_count,
	output logic [cyrc_pkg::LEN_W-1:0]       orbit_period,
	output logic signed [cyrc_pkg::SPIN_W-1:0] total_spin,
	output logic                             is_representative,
	output logic                             momentum_ok,
	output logic                             accepted
);
	import cyrc_pkg::*;

	localparam int NCELL = (MAX_SITES < WORD_BITS) ? MAX_SITES : WORD_BITS;
	localparam logic [LEN_W-1:0] NCELL_V = LEN_W'(NCELL);

	// configuration registers
	logic [LEN_W-1:0]  chain_length_q;
	logic [MOM_W-1:0]  momentum_q;
	logic              spin_filter_q;
	logic [SPIN_W-1:0] target_spin_q;

	// control
	fsm_state_t        state_q, state_d;
	cell_ctrl_t        cell_ctrl;
	logic              take_item;
	logic              mod_start;
	logic              out_load;
	logic              mod_done;
	logic              rem_zero;
	logic              result_valid_q;

	// working registers
	logic [NCELL-1:0]   cur_q;
	logic [NCELL-1:0]   cur_next;
	logic [NCELL-1:0]   word_q;
	logic [NCELL-1:0]   best_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [SHIFT_W-1:0] iter_q;
	logic [LEN_W-1:0]   period_q;
	logic               found_q;
	logic [LEN_W-1:0]   ones_q;
	logic               mom_ok_q;

	// output registers
	logic [WORD_BITS-1:0] canon_q;
	logic [SHIFT_W-1:0]   shift_out_q;
	logic [LEN_W-1:0]     period_out_q;
	logic [SPIN_W-1:0]    spin_out_q;
	logic                 rep_out_q;
	logic                 mom_out_q;
	logic                 acc_out_q;

	logic [LEN_W-1:0]     len_eff;
	logic [LEN_W-1:0]     period_eff;
	logic [SPIN_W-1:0]    spin_val;
	logic [WORD_BITS-1:0] best_ext;
	logic                 rep_val;
	logic                 spin_ok;

	function automatic logic [NCELL-1:0] cur_ring_mask(input logic [SHIFT_W-1:0] last);
		logic [NCELL-1:0] m;
		for (int j = 0; j < NCELL; j++) begin
			m[j] = (SHIFT_W'(j) <= last);
		end
		return m;
	endfunction

	// effective chain length, clamped to 1..NCELL
	always_comb begin
		priority if (chain_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (chain_length_q > NCELL_V) begin
			len_eff = NCELL_V;
		end else begin
			len_eff = chain_length_q;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_length_q <= CHAIN_LENGTH_RST;
			momentum_q     <= '0;
			spin_filter_q  <= 1'b0;
			target_spin_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHAIN_LENGTH: chain_length_q <= cfg_data[LEN_W-1:0];
				REG_MOMENTUM:     momentum_q     <= cfg_data[MOM_W-1:0];
				REG_SPIN_FILTER:  spin_filter_q  <= cfg_data[0];
				REG_TARGET_SPIN:  target_spin_q  <= cfg_data[SPIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// row of site cells
	assign cell_ctrl.load     = take_item;
	assign cell_ctrl.rotate   = (state_q == ST_ROT);
	assign cell_ctrl.last_idx = SHIFT_W'(len_eff - LEN_W'(1));

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		logic right_bit;
		if (k == NCELL - 1) begin : g_end
			assign right_bit = cur_q[0];
		end else begin : g_mid
			assign right_bit = cur_q[k+1];
		end
		cyrc_cell #(
			.IDX(k)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.load_bit (state_word[k]),
			.right_bit(right_bit),
			.wrap_bit (cur_q[0]),
			.site_q   (cur_q[k]),
			.site_next(cur_next[k])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (state_valid) begin
					state_d = (cell_ctrl.last_idx == '0) ? ST_MUL : ST_ROT;
				end
			end
			ST_ROT: begin
				if (iter_q == cell_ctrl.last_idx) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_MOD;
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		state_stall = 1'b1;
		mod_start   = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: state_stall = 1'b0;
			ST_MUL:  mod_start   = 1'b1;
			ST_DONE: out_load    = !result_valid_q || !result_stall;
			default: begin
			end
		endcase
	end

	assign take_item = state_valid && !state_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_stall == 1'b0) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// rotation search
	always_ff @(posedge clk) begin
		if (take_item) begin
			word_q   <= state_word[NCELL-1:0] & cur_ring_mask(cell_ctrl.last_idx);
			best_q   <= state_word[NCELL-1:0] & cur_ring_mask(cell_ctrl.last_idx);
			shift_q  <= '0;
			iter_q   <= SHIFT_W'(1);
			found_q  <= 1'b0;
			period_q <= '0;
			ones_q   <= LEN_W'(state_word[0]);
		end else if (state_q == ST_ROT) begin
			iter_q <= iter_q + 1'b1;
			ones_q <= ones_q + LEN_W'(cur_next[0]);
			if (cur_next < best_q) begin
				best_q  <= cur_next;
				shift_q <= iter_q;
			end
			if (!found_q && cur_next == word_q) begin
				found_q  <= 1'b1;
				period_q <= LEN_W'(iter_q);
			end
		end else if (state_q == ST_MUL) begin
			period_q <= period_eff;
		end
	end

	assign period_eff = found_q ? period_q : len_eff;

	cyrc_pmod u_pmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.period  (period_eff),
		.mom     (momentum_q),
		.divisor (len_eff),
		.done    (mod_done),
		.rem_zero(rem_zero)
	);

	always_ff @(posedge clk) begin
		if (mod_done) begin
			mom_ok_q <= rem_zero;
		end
	end

	// result formation
	always_comb begin
		best_ext             = '0;
		best_ext[NCELL-1:0]  = best_q;
	end

	assign spin_val = SPIN_W'({ones_q, 1'b0}) - SPIN_W'(len_eff);
	assign rep_val  = (shift_q == '0);
	assign spin_ok  = !spin_filter_q || (spin_val == target_spin_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			canon_q      <= best_ext;
			shift_out_q  <= shift_q;
			period_out_q <= period_q;
			spin_out_q   <= spin_val;
			rep_out_q    <= rep_val;
			mom_out_q    <= mom_ok_q;
			acc_out_q    <= rep_val && mom_ok_q && spin_ok;
		end
	end

	assign result_valid      = result_valid_q;
	assign canonical_word    = canon_q;
	assign shift_count       = shift_out_q;
	assign orbit_period      = period_out_q;
	assign total_spin        = spin_out_q;
	assign is_representative = rep_out_q;
	assign momentum_ok       = mom_out_q;
	assign accepted          = acc_out_q;

	a_rep_matches_shift: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (is_representative == (shift_count == '0)))
		else $error("representative flag disagrees with shift count");

	a_accept_implies_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && accepted |-> is_representative && momentum_ok)
		else $error("accept without representative and momentum");

	a_shift_within_period: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (orbit_period != '0) && (LEN_W'(shift_count) < orbit_period))
		else $error("shift count outside first orbit period");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_valid && !state_stall |=> state_stall)
		else $error("second transaction taken while busy");

endmodule

// ===== dv/tb_cyclic_rotation_canonicalizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cyclic_rotation_canonicalizer
// Self-checking bench for the cyclic rotation canonicalizer.
// ----------------------------------------------------------------------------
// A table of hand-picked ring words runs first under the reset settings.
// After it comes a series of register settings, each followed by a batch of
// random words. The settings cover zero, short and saturated chain lengths,
// both momentum extremes, the spin filter on and off, and writes to indexes
// past the register list. The random words are plain, sparse, dense,
// periodic, already canonical or of a fixed population. Typed rows carry their
// results, an in-bench rotation model predicts the rest, all checked field by
// field. The input side idles and the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_cyclic_rotation_canonicalizer;
	import cyrc_pkg::*;

	localparam int CYCLE_CAP   = 1_000_000;
	localparam int DRAIN_CYC   = 64;
	localparam int PHASE_ITEMS = 60;
	localparam int N_FIXED     = 11;
	localparam int N_RANDOM    = 3;

	typedef struct packed {
		logic [WORD_BITS-1:0]     canon;
		logic [SHIFT_W-1:0]       shift;
		logic [LEN_W-1:0]         period;
		logic signed [SPIN_W-1:0] spin;
		logic                     rep;
		logic                     mom_ok;
		logic                     acc;
	} ring_form_t;

	typedef struct {
		logic [WORD_BITS-1:0] word;
		bit                   typed;
		ring_form_t           form;
	} probe_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index    = '0;
	logic [CFG_DATA_W-1:0]    cfg_data     = '0;
	logic                     state_valid  = 1'b0;
	logic                     state_stall;
	logic [WORD_BITS-1:0]     state_word   = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic [WORD_BITS-1:0]     canonical_word;
	logic [SHIFT_W-1:0]       shift_count;
	logic [LEN_W-1:0]         orbit_period;
	logic signed [SPIN_W-1:0] total_spin;
	logic                     is_representative;
	logic                     momentum_ok;
	logic                     accepted;

	// register shadow
	logic [LEN_W-1:0]  len_reg  = CHAIN_LENGTH_RST;
	logic [MOM_W-1:0]  mom_reg  = '0;
	logic              filt_reg = 1'b0;
	logic [SPIN_W-1:0] tgt_reg  = '0;

	ring_form_t pending_forms[$];
	probe_t     probes[$];
	int         fault_cnt = 0;
	int         hold_left = 0;
	bit         quiet     = 1'b0;

	int ph_len  [N_FIXED] = '{0, 1, 2, 3, 63, 33, 32, 31, 12, 16, 7};
	int ph_mom  [N_FIXED] = '{0, 31, 1, 2, 31, 16, 8, 0, 4, 8, 3};
	int ph_filt [N_FIXED] = '{0, 1, 1, 0, 1, 1, 1, 1, 1, 0, 1};
	int ph_tgt  [N_FIXED] = '{0, -1, 0, 0, -32, 32, 0, 5, 2, 0, -3};

	cyclic_rotation_canonicalizer dut (
		.clk,
		.arst_n,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data,
		.state_valid,
		.state_stall,
		.state_word,
		.result_valid,
		.result_stall,
		.canonical_word,
		.shift_count,
		.orbit_period,
		.total_spin,
		.is_representative,
		.momentum_ok,
		.accepted
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int ring_len();
		int n;
		n = int'(len_reg);
		if (n < 1) n = 1;
		if (n > MAX_SITES_DEF) n = MAX_SITES_DEF;
		if (n > WORD_BITS) n = WORD_BITS;
		return n;
	endfunction

	function automatic ring_form_t canonicalize(input logic [WORD_BITS-1:0] raw);
		ring_form_t  f;
		int          n, shift, period, spin;
		logic [63:0] mask, word, best, cur;
		n = ring_len();
		mask = (64'd1 << n) - 64'd1;
		word = {32'd0, raw} & mask;
		best = word;
		cur = word;
		shift = 0;
		period = 0;
		for (int i = 1; i < n; i++) begin
			cur = ((cur >> 1) | ((cur & 64'd1) << (n - 1))) & mask;
			if (cur < best) begin
				best = cur;
				shift = i;
			end
			if (period == 0 && cur == word) period = i;
		end
		if (period == 0) period = n;
		spin = 2 * $countones(word) - n;
		f.canon = best[WORD_BITS-1:0];
		f.shift = SHIFT_W'(shift);
		f.period = LEN_W'(period);
		f.spin = SPIN_W'(spin);
		f.rep = (shift == 0);
		f.mom_ok = ((period * int'(mom_reg)) % n) == 0;
		f.acc = f.rep && f.mom_ok && (!filt_reg || spin == int'($signed(tgt_reg)));
		return f;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_BITS-1:0] gen_word();
		int                   n, p, k, pick;
		logic [WORD_BITS-1:0] mask, w, pat;
		ring_form_t           f;
		n = ring_len();
		mask = WORD_BITS'((64'd1 << n) - 64'd1);
		pick = $urandom_range(0, 99);
		w = $urandom;
		if (pick < 15) begin
			w = $urandom & $urandom & $urandom;
		end else if (pick < 25) begin
			w = $urandom | $urandom | $urandom;
		end else if (pick < 45) begin
			p = $urandom_range(1, n);
			pat = $urandom;
			for (int i = 0; i < WORD_BITS; i++) w[i] = pat[i % p];
		end else if (pick < 65) begin
			f = canonicalize($urandom);
			w = f.canon;
		end else if (pick < 80) begin
			// aim at the filter target population when it is reachable
			k = (int'($signed(tgt_reg)) + n) / 2;
			if (!filt_reg || k < 0 || k > n) k = $urandom_range(0, n);
			w = '0;
			while ($countones(w & mask) < k) w[$urandom_range(0, n - 1)] = 1'b1;
		end else if (pick < 85) begin
			w = $urandom_range(0, 1) ? '1 : '0;
		end
		return (w & mask) | ($urandom & ~mask);
	endfunction

	task automatic add_probe(input logic [WORD_BITS-1:0] word, input bit typed,
			input logic [WORD_BITS-1:0] canon, input int shift, input int period,
			input int spin, input bit rep, input bit mom_ok, input bit acc);
		probe_t pr;
		pr.word = word;
		pr.typed = typed;
		pr.form.canon = canon;
		pr.form.shift = SHIFT_W'(shift);
		pr.form.period = LEN_W'(period);
		pr.form.spin = SPIN_W'(spin);
		pr.form.rep = rep;
		pr.form.mom_ok = mom_ok;
		pr.form.acc = acc;
		probes.push_back(pr);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CHAIN_LENGTH: len_reg = data[LEN_W-1:0];
			REG_MOMENTUM:     mom_reg = data[MOM_W-1:0];
			REG_SPIN_FILTER:  filt_reg = data[0];
			REG_TARGET_SPIN:  tgt_reg = data[SPIN_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits are junk and must be dropped by the block
	task automatic program_ring(input int len_val, input int mom_val, input int filt,
			input int tgt);
		logic [CFG_DATA_W-1:0] junk;
		junk = $urandom;
		cfg_write(CFG_IDX_W'($urandom_range(int'(REG_TARGET_SPIN) + 1, 255)), junk);
		junk = $urandom;
		cfg_write(REG_CHAIN_LENGTH, {junk[7:6], LEN_W'(len_val)});
		junk = $urandom;
		cfg_write(REG_MOMENTUM, {junk[7:5], MOM_W'(mom_val)});
		junk = $urandom;
		cfg_write(REG_SPIN_FILTER, {junk[7:1], 1'(filt)});
		junk = $urandom;
		cfg_write(REG_TARGET_SPIN, {junk[7], SPIN_W'(tgt)});
	endtask

	task automatic send_word(input logic [WORD_BITS-1:0] w, input bit typed,
			input ring_form_t form);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			state_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		state_valid <= 1'b1;
		state_word <= w;
		do @(posedge clk); while (state_stall);
		pending_forms.push_back(typed ? form : canonicalize(w));
	endtask

	task automatic finish_phase();
		state_valid <= 1'b0;
		while (pending_forms.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [WORD_BITS-1:0] want,
			input logic [WORD_BITS-1:0] got);
		if (want !== got) begin
			fault_cnt++;
			if (fault_cnt <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		ring_form_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_forms.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= 10)
					$display("unexpected transaction: canonical_word %0h", canonical_word);
			end else begin
				want = pending_forms.pop_front();
				compare_field("canonical_word", want.canon, canonical_word);
				compare_field("shift_count", WORD_BITS'(want.shift), WORD_BITS'(shift_count));
				compare_field("orbit_period", WORD_BITS'(want.period), WORD_BITS'(orbit_period));
				compare_field("total_spin", WORD_BITS'(unsigned'(want.spin)),
					WORD_BITS'(unsigned'(total_spin)));
				compare_field("is_representative", WORD_BITS'(want.rep),
					WORD_BITS'(is_representative));
				compare_field("momentum_ok", WORD_BITS'(want.mom_ok), WORD_BITS'(momentum_ok));
				compare_field("accepted", WORD_BITS'(want.acc), WORD_BITS'(accepted));
			end
		end
		if (quiet) hold_left = 0;
		else if (hold_left == 0 && $urandom_range(0, 3) == 0) hold_left = pick_gap();
		if (hold_left == 0) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= 1'b1;
			hold_left--;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$display("[cyclic_rotation_canonicalizer] ERROR");
		$finish;
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 32 sites, momentum 0, filter off
		add_probe(32'h0000_0000, 1, 32'h0000_0000, 0, 1, -32, 1, 1, 1);
		add_probe(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 1, 32, 1, 1, 1);
		add_probe(32'h0000_0001, 1, 32'h0000_0001, 0, 32, -30, 1, 1, 1);
		add_probe(32'h8000_0000, 1, 32'h0000_0001, 31, 32, -30, 0, 1, 0);
		add_probe(32'h0001_0000, 1, 32'h0000_0001, 16, 32, -30, 0, 1, 0);
		add_probe(32'h5555_5555, 1, 32'h5555_5555, 0, 2, 0, 1, 1, 1);
		add_probe(32'hAAAA_AAAA, 1, 32'h5555_5555, 1, 2, 0, 0, 1, 0);
		// two rotations tie, the lower count wins
		add_probe(32'h8000_8000, 1, 32'h0001_0001, 15, 16, -28, 0, 1, 0);
		add_probe(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 0, 32, 30, 1, 1, 1);
		add_probe(32'hFFFF_FFFE, 1, 32'h7FFF_FFFF, 1, 32, 30, 0, 1, 0);
		add_probe(32'h1234_5678, 0, '0, 0, 0, 0, 0, 0, 0);
		add_probe(32'hDEAD_BEEF, 0, '0, 0, 0, 0, 0, 0, 0);
		add_probe(32'h0F0F_0F0F, 0, '0, 0, 0, 0, 0, 0, 0);
		add_probe(32'hF0F0_F0F0, 0, '0, 0, 0, 0, 0, 0, 0);
		add_probe(32'h00FF_00FF, 0, '0, 0, 0, 0, 0, 0, 0);
		add_probe(32'h3C3C_3C3C, 0, '0, 0, 0, 0, 0, 0, 0);

		foreach (probes[i]) send_word(probes[i].word, probes[i].typed, probes[i].form);
		for (int i = 0; i < PHASE_ITEMS; i++) send_word(gen_word(), 1'b0, '0);
		finish_phase();

		for (int ph = 0; ph < N_FIXED + N_RANDOM; ph++) begin
			quiet = 1'b0;
			if (ph < N_FIXED)
				program_ring(ph_len[ph], ph_mom[ph], ph_filt[ph], ph_tgt[ph]);
			else
				program_ring($urandom_range(0, 63), $urandom_range(0, 31),
					$urandom_range(0, 1), $urandom_range(0, 127));
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) send_word(gen_word(), 1'b0, '0);
			finish_phase();
		end

		if (fault_cnt == 0 && pending_forms.size() == 0)
			$display("[cyclic_rotation_canonicalizer] OK");
		else
			$display("[cyclic_rotation_canonicalizer] ERROR");
		$finish;
	end

endmodule
